@@ rtl/kcht_pkg.sv @@
// Package for the keyed count hash table: slot geometry, status codes,
// beat and memory-port types, home-slot function. No dependencies.
package kcht_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [63:0] caller_address;
    logic [31:0] pages;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [63:0] slot_total;
  } out_item_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [63:0]       wr_key;
    logic [63:0]       wr_total;
  } mem_req_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] total;
  } mem_rsp_t;

  // key bits 8:3 reduced modulo NUM_SLOTS by restoring subtraction
  function automatic logic [SLOT_W-1:0] home_slot(input logic [63:0] key);
    int unsigned v;
    v = {26'd0, key[8:3]};
    for (int k = 5; k >= 0; k--) begin
      if (v >= (NUM_SLOTS << k)) begin
        v = v - (NUM_SLOTS << k);
      end
    end
    return SLOT_W'(v);
  endfunction

endpackage

@@ rtl/kcht_slot_mem.sv @@
// Slot store: key and total memories with one registered read port and
// one write port; per-slot valid flags make unwritten slots read as zero.
// Depends on kcht_pkg.
module kcht_slot_mem
  import kcht_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [63:0]          key_mem [NUM_SLOTS];
  logic [63:0]          tot_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;
  logic                 rd_vld_r;
  logic [63:0]          rd_key_r;
  logic [63:0]          rd_tot_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr] <= req.wr_key;
      tot_mem[req.wr_addr] <= req.wr_total;
    end
    if (req.rd_en) begin
      rd_key_r <= key_mem[req.rd_addr];
      rd_tot_r <= tot_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rsp.key   = rd_vld_r ? rd_key_r : 64'd0;
  assign rsp.total = rd_vld_r ? rd_tot_r : 64'd0;

endmodule

@@ rtl/kcht_ctrl.sv @@
// Probe sequencer: linear probe one slot per cycle, read-modify-write of
// the slot store, result register on the out channel. Depends on kcht_pkg.
module kcht_ctrl
  import kcht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  output mem_req_t  mem_req,
  input  mem_rsp_t  mem_rsp
);

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_DONE} state_t;

  state_t            state_r;
  logic [63:0]       key_r;
  logic [31:0]       cnt_r;
  logic [SLOT_W-1:0] pos_r;
  logic [SLOT_W-1:0] n_r;
  out_item_t         res_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [SLOT_W-1:0] pos_nxt;
  logic [15:0]       pos_ext;
  logic [63:0]       sum;
  logic              hit;
  logic              empty;
  logic              last;

  assign pos_nxt = (pos_r == SLOT_W'(NUM_SLOTS - 1)) ? '0 : pos_r + 1'b1;
  assign pos_ext = 16'(pos_r);
  assign sum     = mem_rsp.total + {32'd0, cnt_r};
  assign hit     = (mem_rsp.key == key_r);
  assign empty   = (mem_rsp.key == 64'd0);
  assign last    = (n_r == SLOT_W'(NUM_SLOTS - 1));

  always_comb begin
    mem_req          = '0;
    mem_req.wr_addr  = pos_r;
    mem_req.wr_key   = key_r;
    mem_req.wr_total = hit ? sum : {32'd0, cnt_r};
    mem_req.rd_addr  = pos_nxt;
    case (state_r)
      S_IDLE: begin
        mem_req.rd_addr = home_slot(in_data.caller_address);
        mem_req.rd_en   = in_valid && (in_data.caller_address != 64'd0);
      end
      S_PROBE: begin
        mem_req.wr_en = hit || empty;
        mem_req.rd_en = !hit && !empty && !last;
      end
      default: begin
        mem_req.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_r <= in_data.caller_address;
            cnt_r <= in_data.pages;
            pos_r <= home_slot(in_data.caller_address);
            n_r   <= '0;
            if (in_data.caller_address == 64'd0) begin
              res_r   <= '{status: ST_IGNORED, slot_index: 6'd0, slot_total: 64'd0};
              state_r <= S_DONE;
            end else begin
              state_r <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (hit) begin
            res_r   <= '{status: ST_ADDED, slot_index: pos_ext[5:0], slot_total: sum};
            state_r <= S_DONE;
          end else if (empty) begin
            res_r   <= '{status: ST_NEW, slot_index: pos_ext[5:0],
                        slot_total: {32'd0, cnt_r}};
            state_r <= S_DONE;
          end else if (last) begin
            res_r   <= '{status: ST_FULL, slot_index: 6'd0, slot_total: 64'd0};
            state_r <= S_DONE;
          end else begin
            pos_r <= pos_nxt;
            n_r   <= n_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/keyed_count_hash_table.sv @@
// Keyed page-count hash table, top level: probe sequencer plus slot store.
// Depends on kcht_pkg, kcht_ctrl and kcht_slot_mem.
//
// Usage:
//   in channel  : in_valid / in_stall / in_data (caller_address, pages).
//   out channel : out_valid / out_stall / out_data (status, slot_index,
//                 slot_total). One out beat per in beat, in order.
//   A zero address is ignored. Otherwise the home slot is address bits 8:3
//   modulo NUM_SLOTS and probing runs linearly with wraparound; a matching
//   slot accumulates, the first empty slot is claimed, a full table drops.
// Timing:
//   One slot is probed per cycle through the store's single read port.
//   An item probes 1 to NUM_SLOTS slots and then loads the out register;
//   a zero key skips probing. in_stall stays high from accept until the
//   result is loaded, so the next beat waits for it.
// Reset (rst_n low, synchronous): all slots read as empty with zero totals
//   at once via per-slot valid flags; no clearing pass.
// Stall: out_data is held in a register. A new beat is accepted while a
//   result waits; that item finishes its probe and then waits for the
//   register, holding in_stall high.
module keyed_count_hash_table
  import kcht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  kcht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  kcht_slot_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rsp   (mem_rsp)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted a beat without going busy");

  a_no_rd_on_wr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> !mem_req.rd_en)
    else $error("slot read issued alongside write-back");

  a_no_wr_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !mem_req.wr_en)
    else $error("slot write while idle");

  a_null_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL || out_data.status == ST_IGNORED))
      |-> (out_data.slot_index == 6'd0 && out_data.slot_total == 64'd0))
    else $error("dropped or ignored beat carries slot data");

endmodule
